// File: rtl/gcshs_pkg.sv
// ----------------------------------------------------------------------------
// GNSS cycle slip / Hatch smoother package
// Shared widths, the per-satellite table entry, register indexes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package gcshs_pkg;

  localparam int NUM_SV     = 64;   // table depth, a power of two
  localparam int RANGE_BITS = 48;   // range field width
  localparam int SV_IDX_W   = $clog2(NUM_SV);

  localparam int CMC_W   = RANGE_BITS + 1;  // code minus carrier
  localparam int DIFF_W  = RANGE_BITS + 2;  // step of code minus carrier
  localparam int VAR_W   = 48;              // variance, mm^2
  localparam int SQ_BITS = 28;              // step magnitudes below 2^28 are squared
  localparam int MUL_A_W = SQ_BITS;
  localparam int MUL_B_W = VAR_W;
  localparam int MUL_H_W = MUL_B_W / 2;     // half of the wide operand per pass
  localparam int MUL_HP_W = MUL_A_W + MUL_H_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int PRED_W  = RANGE_BITS + 2;  // predicted smoothed range
  localparam int NUM_W   = RANGE_BITS + 3;  // code minus prediction
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam logic [VAR_W-1:0] VAR_MAX = '1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HATCH_ENABLE = 3'd0;
  localparam logic [2:0] CFG_WINDOW_MAX   = 3'd1;
  localparam logic [2:0] CFG_SIGMA_K_SQ   = 3'd2;
  localparam logic [2:0] CFG_SLIP_FLOOR   = 3'd3;
  localparam logic [2:0] CFG_EMA_WEIGHT   = 3'd4;
  localparam logic [2:0] CFG_WARMUP       = 3'd5;

  typedef struct packed {
    logic signed [CMC_W-1:0]      cmc_prev;
    logic [VAR_W-1:0]             cmc_variance;
    logic [31:0]                  cmc_session;
    logic [7:0]                   cmc_count;
    logic [15:0]                  break_prev;
    logic [31:0]                  break_session;
    logic                         break_primed;
    logic [7:0]                   hatch_count;
    logic [31:0]                  hatch_session;
    logic [1:0]                   hatch_code;
    logic signed [RANGE_BITS-1:0] hatch_smooth;
    logic signed [RANGE_BITS-1:0] hatch_phase_prev;
  } sv_entry_t;

  localparam int ENTRY_W = $bits(sv_entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIFF,
    ST_SQ,
    ST_THR,
    ST_VA,
    ST_VB,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } seq_state_t;

endpackage

// File: rtl/gcshs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcshs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gnss_cycle_slip_hatch_smoother.sv
// ----------------------------------------------------------------------------
// GNSS cycle slip detector and Hatch carrier smoother
// Per-satellite code-minus-carrier slip test with an adaptive variance,
// lock-break slip test, and Hatch smoothing of the code range.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Contents
//   input     in         in_valid / in_stall   sv_index, ranges, session, breaks, code
//   output    out        out_valid / out_stall sv_echo, smoothed_range, slips, arc
//   config    in         cfg_write             cfg_index, cfg_data
//
// An observation skips the divider when the Hatch filter restarts or is disabled
// and passes through it when it smooths; the result may then wait on out_stall.
// The next transfer can come in the cycle after the result is loaded, so a new
// item is not taken before the previous result is loaded.
// The restoring divider resolves one quotient bit of (code - prediction) / n
// per cycle over RANGE_BITS + 3 bits, and the single 28 x 24 multiplier forms
// each of the four products of an observation in two passes, one per half of
// the wide operand.
// Reset is synchronous and clears the sequencer, the output valid and the table
// valid bits, and sets the configuration registers to their reset defaults; a
// never-written entry reads as zero. in_stall is high from the transfer of an
// item until its result is loaded into the output register, so a new item may
// be taken while the previous result still waits for its transfer.
// ----------------------------------------------------------------------------
module gnss_cycle_slip_hatch_smoother
  import gcshs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [5:0]                   sv_index,
  input  logic signed [RANGE_BITS-1:0] code_range,
  input  logic signed [RANGE_BITS-1:0] carrier_range,
  input  logic [31:0]                  track_session,
  input  logic [15:0]                  lock_break_count,
  input  logic [1:0]                   signal_code,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [5:0]                   sv_echo,
  output logic signed [RANGE_BITS-1:0] smoothed_range,
  output logic                         code_slip,
  output logic                         carrier_slip,
  output logic [7:0]                   arc_length,
  // configuration port
  input  logic                         cfg_write,
  input  logic [2:0]                   cfg_index,
  input  logic [19:0]                  cfg_data
);

  // Configuration registers.
  logic        hatch_enable;
  logic [7:0]  window_max;
  logic [15:0] sigma_k_squared;
  logic [19:0] slip_floor;
  logic [15:0] ema_weight;
  logic [7:0]  warmup_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      hatch_enable    <= 1'b0;
      window_max      <= 8'd100;
      sigma_k_squared <= 16'd4096;
      slip_floor      <= 20'd5000;
      ema_weight      <= 16'd3277;
      warmup_count    <= 8'd10;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HATCH_ENABLE: hatch_enable    <= cfg_data[0];
        CFG_WINDOW_MAX:   window_max      <= cfg_data[7:0];
        CFG_SIGMA_K_SQ:   sigma_k_squared <= cfg_data[15:0];
        CFG_SLIP_FLOOR:   slip_floor      <= cfg_data;
        CFG_EMA_WEIGHT:   ema_weight      <= cfg_data[15:0];
        CFG_WARMUP:       warmup_count    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  seq_state_t state, state_next;

  // Latched observation.
  logic [5:0]                   sv_r;
  logic [SV_IDX_W-1:0]          idx_r;
  logic signed [RANGE_BITS-1:0] code_r;
  logic signed [RANGE_BITS-1:0] phase_r;
  logic [31:0]                  sess_r;
  logic [15:0]                  brk_r;
  logic [1:0]                   sig_r;

  // Working registers.
  sv_entry_t                ent;       // entry as read
  sv_entry_t                upd;       // entry being built
  sv_entry_t                upd_next;
  logic signed [CMC_W-1:0]  cmc_r;
  logic                     seed_r;
  logic [DIFF_W-1:0]        ad_r;      // |step|
  logic                     big_ad_r;
  logic [2*SQ_BITS-1:0]     sqp_r;     // exact step squared
  logic [VAR_W-1:0]         sq_r;      // clamped step squared
  logic [MUL_P_W-8-1:0]     thr_r;
  logic                     cslip_r;
  logic                     kslip_r;
  logic [MUL_P_W-1:0]       acc_r;
  logic [MUL_P_W-1:0]       prod_r;
  logic                     restart_r;
  logic [7:0]               n_r;
  logic signed [PRED_W-1:0] pred_r;
  logic                     neg_r;
  logic [NUM_W-1:0]         quo_r;
  logic [7:0]               rem_r;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic                     hatch_restart;

  logic [NUM_SV-1:0] vld;

  // Table storage.
  logic                ram_we;
  logic [SV_IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  sv_entry_t           fin;

  gcshs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SV)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (fin),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared multiplier. Each product takes two passes: the first multiplies by
  // the low half of the wide operand and keeps it, the second adds the high
  // half shifted into place.
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_H_W-1:0]  mul_bh;
  logic [MUL_HP_W-1:0] mul_half;
  logic [MUL_P_W-1:0]  mul_lo_r;
  logic [MUL_P_W-1:0]  mul_p;
  logic                mul_ph;
  logic                mul_busy;

  assign mul_bh   = mul_ph ? mul_b[MUL_B_W-1:MUL_H_W] : mul_b[MUL_H_W-1:0];
  assign mul_half = MUL_HP_W'(mul_a) * MUL_HP_W'(mul_bh);
  assign mul_p    = mul_lo_r + (MUL_P_W'(mul_half) << MUL_H_W);

  always_ff @(posedge clk) begin
    if (!mul_ph) mul_lo_r <= MUL_P_W'(mul_half);
  end

  logic in_xfer, out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_DIFF;
      ST_DIFF: state_next = ST_SQ;
      ST_SQ:   if (mul_ph) state_next = ST_THR;
      ST_THR:  if (mul_ph) state_next = ST_VA;
      ST_VA:   if (mul_ph) state_next = ST_VB;
      ST_VB:   if (mul_ph) state_next = ST_PREP;
      ST_PREP: begin
        if (hatch_enable && !hatch_restart) state_next = ST_DIV;
        else state_next = ST_DONE;
      end
      ST_DIV:  if (div_cnt == DIV_CNT_W'(NUM_W - 1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    ram_we    = (state == ST_DONE) && out_free;
    ram_raddr = (state == ST_IDLE) ? sv_index[SV_IDX_W-1:0] : idx_r;
    mul_a     = '0;
    mul_b     = '0;
    mul_busy  = 1'b0;
    case (state)
      ST_SQ: begin
        mul_busy = 1'b1;
        mul_a    = ad_r[SQ_BITS-1:0];
        mul_b    = MUL_B_W'(ad_r[SQ_BITS-1:0]);
      end
      ST_THR: begin
        mul_busy = 1'b1;
        mul_a    = MUL_A_W'(sigma_k_squared);
        mul_b    = ent.cmc_variance;
      end
      ST_VA: begin
        mul_busy = 1'b1;
        mul_a    = MUL_A_W'(17'h10000 - 17'(ema_weight));
        mul_b    = ent.cmc_variance;
      end
      ST_VB: begin
        mul_busy = 1'b1;
        mul_a    = MUL_A_W'(ema_weight);
        mul_b    = sq_r;
      end
      default: ;
    endcase
  end

  // Step of code minus carrier and its magnitude.
  logic signed [DIFF_W-1:0] diff;
  assign diff = DIFF_W'(cmc_r) - DIFF_W'(ent.cmc_prev);

  // The slip decision: warm arc, step above the floor, and d^2 > k^2 * var.
  logic code_slip_now;
  assign code_slip_now = !seed_r && (ent.cmc_count >= warmup_count) &&
                         (ad_r > DIFF_W'(slip_floor)) &&
                         (big_ad_r || (MUL_P_W'(sqp_r) > MUL_P_W'(thr_r)));

  // Variance update, weights summing to 2^16.
  logic [MUL_P_W:0] var_sum;
  assign var_sum = (MUL_P_W+1)'(acc_r) + (MUL_P_W+1)'(prod_r);

  logic kslip_now;
  assign kslip_now = ent.break_primed && (ent.break_session == sess_r) &&
                     (brk_r > ent.break_prev);

  // Hatch arc restart and smoothing count.
  logic [7:0] win;
  logic [8:0] n_inc;
  logic [7:0] n_new;
  assign hatch_restart = (ent.hatch_count == 8'd0) || (ent.hatch_session != sess_r) ||
                         (ent.hatch_code != sig_r) || cslip_r || kslip_now;
  assign win   = (window_max == 8'd0) ? 8'd1 : window_max;
  assign n_inc = 9'(ent.hatch_count) + 9'd1;
  assign n_new = (n_inc > 9'(win)) ? win : n_inc[7:0];

  logic signed [PRED_W-1:0] pred;
  logic signed [NUM_W-1:0]  num;
  assign pred = PRED_W'(ent.hatch_smooth) +
                (PRED_W'(phase_r) - PRED_W'(ent.hatch_phase_prev));
  assign num  = NUM_W'(code_r) - NUM_W'(pred);

  // Updated entry; the smoothed range is replaced once the divider is done.
  always_comb begin
    upd_next = ent;
    if (seed_r) begin
      upd_next.cmc_variance = '0;
      upd_next.cmc_count    = 8'd1;
    end else begin
      if (!cslip_r) upd_next.cmc_variance = var_sum[VAR_W+15:16];
      if (ent.cmc_count != 8'd255) upd_next.cmc_count = ent.cmc_count + 8'd1;
    end
    upd_next.cmc_prev      = cmc_r;
    upd_next.cmc_session   = sess_r;
    upd_next.break_prev    = brk_r;
    upd_next.break_session = sess_r;
    upd_next.break_primed  = 1'b1;
    if (hatch_enable) begin
      upd_next.hatch_count      = hatch_restart ? 8'd1 : n_new;
      upd_next.hatch_session    = sess_r;
      upd_next.hatch_code       = sig_r;
      upd_next.hatch_phase_prev = phase_r;
      upd_next.hatch_smooth     = code_r;
    end
  end

  // Restoring divider step.
  logic [8:0] rem_sh;
  logic       div_ge;
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign div_ge = rem_sh >= 9'(n_r);

  // Final smoothed value, truncated toward zero and saturated.
  localparam int SUM_W = NUM_W + 1;
  logic signed [SUM_W-1:0] quot_s;
  logic signed [SUM_W-1:0] sum;
  logic signed [RANGE_BITS-1:0] smooth_sat;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(RANGE_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  always_comb begin
    quot_s = neg_r ? -SUM_W'(quo_r) : SUM_W'(quo_r);
    sum    = SUM_W'(pred_r) + quot_s;
    if (sum > SAT_HI) smooth_sat = SAT_HI[RANGE_BITS-1:0];
    else if (sum < SAT_LO) smooth_sat = SAT_LO[RANGE_BITS-1:0];
    else smooth_sat = sum[RANGE_BITS-1:0];
    fin = upd;
    if (hatch_enable && !restart_r) fin.hatch_smooth = smooth_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      vld       <= '0;
      mul_ph    <= 1'b0;
    end else begin
      state  <= state_next;
      mul_ph <= mul_busy && !mul_ph;
      if (ram_we) begin
        out_valid  <= 1'b1;
        vld[idx_r] <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          sv_r    <= sv_index;
          idx_r   <= sv_index[SV_IDX_W-1:0];
          code_r  <= code_range;
          phase_r <= carrier_range;
          sess_r  <= track_session;
          brk_r   <= lock_break_count;
          sig_r   <= signal_code;
        end
      end
      ST_LOAD: begin
        ent   <= vld[idx_r] ? sv_entry_t'(ram_rdata) : '0;
        cmc_r <= CMC_W'(code_r) - CMC_W'(phase_r);
      end
      ST_DIFF: begin
        seed_r   <= (ent.cmc_count == 8'd0) || (ent.cmc_session != sess_r);
        ad_r     <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      end
      ST_SQ: begin
        if (mul_ph) begin
          big_ad_r <= |ad_r[DIFF_W-1:SQ_BITS];
          sqp_r    <= mul_p[2*SQ_BITS-1:0];
          if ((|ad_r[DIFF_W-1:SQ_BITS]) || (|mul_p[2*SQ_BITS-1:VAR_W])) sq_r <= VAR_MAX;
          else sq_r <= mul_p[VAR_W-1:0];
        end
      end
      ST_THR: if (mul_ph) thr_r <= mul_p[MUL_P_W-1:8];
      ST_VA: begin
        if (mul_ph) begin
          cslip_r <= code_slip_now;
          acc_r   <= mul_p;
        end
      end
      ST_VB: if (mul_ph) prod_r <= mul_p;
      ST_PREP: begin
        upd       <= upd_next;
        kslip_r   <= kslip_now;
        restart_r <= hatch_restart;
        n_r       <= n_new;
        pred_r    <= pred;
        neg_r     <= num[NUM_W-1];
        quo_r     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        rem_r     <= '0;
        div_cnt   <= '0;
      end
      ST_DIV: begin
        rem_r   <= div_ge ? 8'(rem_sh - 9'(n_r)) : rem_sh[7:0];
        quo_r   <= {quo_r[NUM_W-2:0], div_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          sv_echo        <= sv_r;
          smoothed_range <= hatch_enable ? fin.hatch_smooth : code_r;
          code_slip      <= cslip_r;
          carrier_slip   <= kslip_r;
          arc_length     <= hatch_enable ? fin.hatch_count : 8'd0;
        end
      end
      default: ;
    endcase
  end

  // A transfer on the input makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> in_stall)
    else $error("block did not go busy after an input transfer");

  // Any slip restarts the smoothing arc.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (code_slip || carrier_slip) |-> arc_length <= 8'd1)
    else $error("slip did not restart the arc");

  // The arc never exceeds the effective window.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (arc_length <= window_max) || (arc_length <= 8'd1))
    else $error("arc length beyond window");

  // The table is written once per item, when the result is loaded.
  assert property (@(posedge clk) disable iff (rst) ram_we |=> out_valid && !ram_we)
    else $error("table write without result");

endmodule
